// ===== rtl/via_pkg.sv =====
// Shared types and constants for the versatile interface adapter.
// No dependencies; every other file in rtl/ imports this package.
package via_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } via_func_t;

  // Register map, standard numbering
  localparam logic [3:0] ADDR_ORB   = 4'd0;
  localparam logic [3:0] ADDR_ORA   = 4'd1;
  localparam logic [3:0] ADDR_DDRB  = 4'd2;
  localparam logic [3:0] ADDR_DDRA  = 4'd3;
  localparam logic [3:0] ADDR_T1CL  = 4'd4;
  localparam logic [3:0] ADDR_T1CH  = 4'd5;
  localparam logic [3:0] ADDR_T1LL  = 4'd6;
  localparam logic [3:0] ADDR_T1LH  = 4'd7;
  localparam logic [3:0] ADDR_T2CL  = 4'd8;
  localparam logic [3:0] ADDR_T2CH  = 4'd9;
  localparam logic [3:0] ADDR_SR    = 4'd10;
  localparam logic [3:0] ADDR_ACR   = 4'd11;
  localparam logic [3:0] ADDR_PCR   = 4'd12;
  localparam logic [3:0] ADDR_IFR   = 4'd13;
  localparam logic [3:0] ADDR_IER   = 4'd14;
  localparam logic [3:0] ADDR_ORANH = 4'd15;

  // ACR bit positions
  localparam int ACR_PA_LATCH = 0;
  localparam int ACR_PB_LATCH = 1;
  localparam int ACR_T1_CONT  = 6;
  localparam int ACR_PB7_OUT  = 7;

  // Timer status seen by the port logic
  typedef struct packed {
    logic       pb7;       // current PB7 level from timer 1
    logic       pb7_next;  // PB7 level after this item
    logic       upd_b;     // timer asks for a port B notification
    logic [7:0] rd;        // read byte for timer addresses, zero otherwise
  } via_tmr_stat_t;

  // Item result from the port logic
  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] a_value;
    logic       a_upd;
    logic [7:0] b_value;
    logic       b_upd;
  } via_port_res_t;

endpackage

// ===== rtl/via_timers.sv =====
// Timer 1 and timer 2 counters, latches and the timer 1 PB7 level.
// Depends on via_pkg.
module via_timers (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  via_pkg::via_func_t    func,
  input  logic [3:0]            reg_addr,
  input  logic [7:0]            write_data,
  input  logic [7:0]            aux_control,
  output via_pkg::via_tmr_stat_t stat
);
  import via_pkg::*;

  logic [15:0] timer1_count, timer1_count_next;
  logic [7:0]  timer1_latch_low, timer1_latch_low_next;
  logic [7:0]  timer1_latch_high, timer1_latch_high_next;
  logic [15:0] timer2_count, timer2_count_next;
  logic [7:0]  timer2_latch_low, timer2_latch_low_next;
  logic        timer1_pb7, timer1_pb7_next;
  logic [15:0] t1_dec;
  logic        upd_b;
  logic [7:0]  rd;

  assign t1_dec = timer1_count - 16'd1;

  always_comb begin
    timer1_count_next      = timer1_count;
    timer1_latch_low_next  = timer1_latch_low;
    timer1_latch_high_next = timer1_latch_high;
    timer2_count_next      = timer2_count;
    timer2_latch_low_next  = timer2_latch_low;
    timer1_pb7_next        = timer1_pb7;
    upd_b                  = 1'b0;
    rd                     = 8'h00;
    case (func)
      FUNC_TICK: begin
        timer1_count_next = t1_dec;
        timer2_count_next = timer2_count - 16'd1;
        if (t1_dec == 16'h0000) begin
          if (aux_control[ACR_T1_CONT]) begin
            timer1_pb7_next   = ~timer1_pb7;
            timer1_count_next = {timer1_latch_high, timer1_latch_low};
          end else begin
            timer1_pb7_next = 1'b1;
          end
          upd_b = aux_control[ACR_PB7_OUT];
        end
      end
      FUNC_WRITE: begin
        unique case (reg_addr)
          ADDR_T1CL, ADDR_T1LL: timer1_latch_low_next = write_data;
          ADDR_T1LH:            timer1_latch_high_next = write_data;
          ADDR_T1CH: begin
            timer1_latch_high_next = write_data;
            timer1_count_next      = {write_data, timer1_latch_low};
            timer1_pb7_next        = 1'b0;
            upd_b                  = aux_control[ACR_PB7_OUT];
          end
          ADDR_T2CL: timer2_latch_low_next = write_data;
          ADDR_T2CH: timer2_count_next = {write_data, timer2_latch_low};
          default: ;
        endcase
      end
      FUNC_READ: begin
        unique case (reg_addr)
          ADDR_T1CL: rd = timer1_count[7:0];
          ADDR_T1CH: rd = timer1_count[15:8];
          ADDR_T1LL: rd = timer1_latch_low;
          ADDR_T1LH: rd = timer1_latch_high;
          ADDR_T2CL: rd = timer2_count[7:0];
          ADDR_T2CH: rd = timer2_count[15:8];
          default:   rd = 8'h00;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer1_count      <= '0;
      timer1_latch_low  <= '0;
      timer1_latch_high <= '0;
      timer2_count      <= '0;
      timer2_latch_low  <= '0;
      timer1_pb7        <= 1'b0;
    end else if (go) begin
      timer1_count      <= timer1_count_next;
      timer1_latch_low  <= timer1_latch_low_next;
      timer1_latch_high <= timer1_latch_high_next;
      timer2_count      <= timer2_count_next;
      timer2_latch_low  <= timer2_latch_low_next;
      timer1_pb7        <= timer1_pb7_next;
    end
  end

  assign stat.pb7      = timer1_pb7;
  assign stat.pb7_next = timer1_pb7_next;
  assign stat.upd_b    = upd_b;
  assign stat.rd       = rd;

endmodule

// ===== rtl/via_ports.sv =====
// Port A/B output and direction registers, ACR and PCR, with the item result.
// Depends on via_pkg; takes timer status from via_timers.
module via_ports (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  via_pkg::via_func_t     func,
  input  logic [3:0]             reg_addr,
  input  logic [7:0]             write_data,
  input  logic [7:0]             port_a_pins,
  input  logic [7:0]             port_b_pins,
  input  via_pkg::via_tmr_stat_t tmr,
  output logic [7:0]             aux_control,
  output via_pkg::via_port_res_t res
);
  import via_pkg::*;

  logic [7:0] port_a_output, port_a_output_next;
  logic [7:0] port_b_output, port_b_output_next;
  logic [7:0] dir_a, dir_a_next;
  logic [7:0] dir_b, dir_b_next;
  logic [7:0] aux_control_next;
  logic [7:0] periph_control, periph_control_next;
  logic [7:0] sense_a, sense_b, drive_b;
  logic       upd_a, upd_b;
  logic [7:0] rd;

  // Read view: output bits from the register, input bits from the pins
  always_comb begin
    sense_a = (port_a_output & dir_a) | (port_a_pins & ~dir_a);
    sense_b = (port_b_output & dir_b) | (port_b_pins & ~dir_b);
    if (aux_control[ACR_PB7_OUT]) sense_b[7] = tmr.pb7;
  end

  always_comb begin
    port_a_output_next  = port_a_output;
    port_b_output_next  = port_b_output;
    dir_a_next          = dir_a;
    dir_b_next          = dir_b;
    aux_control_next    = aux_control;
    periph_control_next = periph_control;
    upd_a               = 1'b0;
    upd_b               = 1'b0;
    rd                  = 8'h00;
    case (func)
      FUNC_WRITE: begin
        unique case (reg_addr)
          ADDR_ORB: begin
            port_b_output_next = write_data;
            upd_b              = (dir_b != 8'h00);
          end
          ADDR_ORA, ADDR_ORANH: begin
            port_a_output_next = write_data;
            upd_a              = (dir_a != 8'h00);
          end
          ADDR_DDRB: begin
            dir_b_next = write_data;
            upd_b      = (write_data != dir_b);
          end
          ADDR_DDRA: begin
            dir_a_next = write_data;
            upd_a      = (write_data != dir_a);
          end
          ADDR_ACR: begin
            aux_control_next = write_data;
            upd_b            = 1'b1;
          end
          ADDR_PCR: periph_control_next = write_data;
          default: ;
        endcase
      end
      FUNC_READ: begin
        unique case (reg_addr)
          ADDR_ORB:             rd = aux_control[ACR_PB_LATCH] ? 8'h00 : sense_b;
          ADDR_ORA, ADDR_ORANH: rd = aux_control[ACR_PA_LATCH] ? 8'h00 : sense_a;
          ADDR_DDRB:            rd = dir_b;
          ADDR_DDRA:            rd = dir_a;
          ADDR_ACR:             rd = aux_control;
          ADDR_PCR:             rd = periph_control;
          default:              rd = tmr.rd;
        endcase
      end
      default: ;
    endcase
  end

  // Driven bytes reflect the state left by this item
  always_comb begin
    drive_b = (port_b_output_next & dir_b_next) | ~dir_b_next;
    if (aux_control_next[ACR_PB7_OUT]) drive_b[7] = tmr.pb7_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_output  <= '0;
      port_b_output  <= '0;
      dir_a          <= '0;
      dir_b          <= '0;
      aux_control    <= '0;
      periph_control <= '0;
    end else if (go) begin
      port_a_output  <= port_a_output_next;
      port_b_output  <= port_b_output_next;
      dir_a          <= dir_a_next;
      dir_b          <= dir_b_next;
      aux_control    <= aux_control_next;
      periph_control <= periph_control_next;
    end
  end

  assign res.rd      = rd;
  assign res.a_value = (port_a_output_next & dir_a_next) | ~dir_a_next;
  assign res.a_upd   = upd_a;
  assign res.b_value = drive_b;
  assign res.b_upd   = upd_b | tmr.upd_b;

endmodule

// ===== rtl/versatile_interface_adapter.sv =====
// Top level of the versatile interface adapter: input register, port and
// timer logic, result register. Depends on via_pkg, via_timers, via_ports.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   func, reg_addr, write_data, port_a_pins, port_b_pins
//   out       out_valid / out_stall read_data, port_a_value, port_a_update,
//                                   port_b_value, port_b_update
//
// One item per cycle sustained while the output does not stall; each item is held
// in the input register and moves to the result register when that can advance,
// and its result is then offered from the result register.
// State changes when an item leaves the input register for the result register.
// A stall on the output holds the result and then the input register; the
// input side stalls only when the input register is full and cannot advance.
// Reset is synchronous and clears all registers of the chip model.
module versatile_interface_adapter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [3:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [7:0] port_a_pins,
  input  logic [7:0] port_b_pins,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [7:0] port_a_value,
  output logic       port_a_update,
  output logic [7:0] port_b_value,
  output logic       port_b_update
);
  import via_pkg::*;

  logic          s1_valid;
  via_func_t     s1_func;
  logic [3:0]    s1_addr;
  logic [7:0]    s1_data;
  logic [7:0]    s1_pins_a;
  logic [7:0]    s1_pins_b;
  logic          advance;
  logic          go;
  logic          take;
  logic [7:0]    aux_control;
  via_tmr_stat_t tmr;
  via_port_res_t res;

  assign advance  = !out_valid || !out_stall;
  assign go       = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_func   <= via_func_t'(func);
      s1_addr   <= reg_addr;
      s1_data   <= write_data;
      s1_pins_a <= port_a_pins;
      s1_pins_b <= port_b_pins;
    end
  end

  via_timers u_timers (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .func        (s1_func),
    .reg_addr    (s1_addr),
    .write_data  (s1_data),
    .aux_control (aux_control),
    .stat        (tmr)
  );

  via_ports u_ports (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .func        (s1_func),
    .reg_addr    (s1_addr),
    .write_data  (s1_data),
    .port_a_pins (s1_pins_a),
    .port_b_pins (s1_pins_b),
    .tmr         (tmr),
    .aux_control (aux_control),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_data     <= res.rd;
      port_a_value  <= res.a_value;
      port_a_update <= res.a_upd;
      port_b_value  <= res.b_value;
      port_b_update <= res.b_upd;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the versatile interface adapter: directed port, timer and
// register tests, then random traffic, all checked against an in-bench model of the chip.
// Depends on rtl/via_pkg.sv and rtl/versatile_interface_adapter.sv.
module tb_top;
  import via_pkg::*;

  localparam int CLK_HALF_NS = 6;
  localparam int TIMEOUT_NS  = 5_000_000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] func;
  logic [3:0] reg_addr;
  logic [7:0] write_data;
  logic [7:0] port_a_pins;
  logic [7:0] port_b_pins;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_data;
  logic [7:0] port_a_value;
  logic       port_a_update;
  logic [7:0] port_b_value;
  logic       port_b_update;

  versatile_interface_adapter DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .reg_addr      (reg_addr),
    .write_data    (write_data),
    .port_a_pins   (port_a_pins),
    .port_b_pins   (port_b_pins),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .port_a_value  (port_a_value),
    .port_a_update (port_a_update),
    .port_b_value  (port_b_value),
    .port_b_update (port_b_update)
  );

  // Chip state as the bench sees it
  logic [7:0]  ora_q = '0, orb_q = '0, ddra_q = '0, ddrb_q = '0, acr_q = '0, pcr_q = '0;
  logic [7:0]  t1_lo_latch = '0, t1_hi_latch = '0, t2_lo_latch = '0, t2_hi_latch = '0;
  logic [15:0] t1_cnt = '0, t2_cnt = '0;
  logic        t1_pb7_q = 1'b0, t1_run_q = 1'b0, t2_run_q = 1'b0;

  via_port_res_t expected_results[$];
  int mismatch_count = 0;
  int n_items = 0, n_ticks = 0, n_writes = 0, n_reads = 0, n_ignored = 0;
  int n_upd_a = 0, n_upd_b = 0, n_results = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout at %0t with %0d results outstanding", $time, expected_results.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] port_a_drive();
    return (ora_q & ddra_q) | ~ddra_q;
  endfunction

  function automatic logic [7:0] port_b_drive();
    logic [7:0] v;
    v = (orb_q & ddrb_q) | ~ddrb_q;
    if (acr_q[ACR_PB7_OUT]) v[7] = t1_pb7_q;
    return v;
  endfunction

  function automatic logic [7:0] port_b_sense(logic [7:0] pins);
    logic [7:0] v;
    v = (orb_q & ddrb_q) | (pins & ~ddrb_q);
    if (acr_q[ACR_PB7_OUT]) v[7] = t1_pb7_q;
    return v;
  endfunction

  // Advance the chip state by one item and return the result it should produce
  function automatic via_port_res_t predict_access(via_func_t f, logic [3:0] a, logic [7:0] d,
                                                   logic [7:0] pa, logic [7:0] pb);
    via_port_res_t r;
    r = '0;
    case (f)
      FUNC_TICK: begin
        t1_cnt = t1_cnt - 16'd1;
        if (t1_cnt == 16'd0) begin
          if (acr_q[ACR_T1_CONT]) begin
            t1_pb7_q = ~t1_pb7_q;
            t1_cnt   = {t1_hi_latch, t1_lo_latch};
          end else begin
            t1_pb7_q = 1'b1;
            t1_run_q = 1'b0;
          end
          if (acr_q[ACR_PB7_OUT]) r.b_upd = 1'b1;
        end
        t2_cnt = t2_cnt - 16'd1;
        if (t2_cnt == 16'd0) t2_run_q = 1'b0;
      end
      FUNC_WRITE: begin
        case (a)
          ADDR_ORB: begin
            orb_q = d;
            if (ddrb_q != 8'd0) r.b_upd = 1'b1;
          end
          ADDR_ORA, ADDR_ORANH: begin
            ora_q = d;
            if (ddra_q != 8'd0) r.a_upd = 1'b1;
          end
          ADDR_DDRB: begin
            if (d != ddrb_q) begin
              ddrb_q  = d;
              r.b_upd = 1'b1;
            end
          end
          ADDR_DDRA: begin
            if (d != ddra_q) begin
              ddra_q  = d;
              r.a_upd = 1'b1;
            end
          end
          ADDR_T1CL, ADDR_T1LL: t1_lo_latch = d;
          ADDR_T1LH: t1_hi_latch = d;
          ADDR_T1CH: begin
            t1_hi_latch = d;
            t1_cnt      = {t1_hi_latch, t1_lo_latch};
            t1_pb7_q    = 1'b0;
            if (acr_q[ACR_PB7_OUT]) r.b_upd = 1'b1;
            t1_run_q    = 1'b1;
          end
          ADDR_T2CL: t2_lo_latch = d;
          ADDR_T2CH: begin
            t2_hi_latch = d;
            t2_cnt      = {t2_hi_latch, t2_lo_latch};
            t2_run_q    = 1'b1;
          end
          ADDR_ACR: begin
            acr_q   = d;
            r.b_upd = 1'b1;
            if (acr_q[ACR_T1_CONT]) t1_run_q = 1'b1;
          end
          ADDR_PCR: pcr_q = d;
          default: ;
        endcase
      end
      FUNC_READ: begin
        case (a)
          ADDR_ORB:             r.rd = acr_q[ACR_PB_LATCH] ? 8'd0 : port_b_sense(pb);
          ADDR_ORA, ADDR_ORANH: r.rd = acr_q[ACR_PA_LATCH] ? 8'd0
                                       : (ora_q & ddra_q) | (pa & ~ddra_q);
          ADDR_DDRB:            r.rd = ddrb_q;
          ADDR_DDRA:            r.rd = ddra_q;
          ADDR_T1CL:            r.rd = t1_cnt[7:0];
          ADDR_T1CH:            r.rd = t1_cnt[15:8];
          ADDR_T1LL:            r.rd = t1_lo_latch;
          ADDR_T1LH:            r.rd = t1_hi_latch;
          ADDR_T2CL:            r.rd = t2_cnt[7:0];
          ADDR_T2CH:            r.rd = t2_cnt[15:8];
          ADDR_ACR:             r.rd = acr_q;
          ADDR_PCR:             r.rd = pcr_q;
          default:              r.rd = 8'd0;
        endcase
      end
      default: ;
    endcase
    r.a_value = port_a_drive();
    r.b_value = port_b_drive();
    return r;
  endfunction

  // Present one item, hold it until accepted, then record what it should produce
  task automatic send_item(via_func_t f, logic [3:0] a, logic [7:0] d,
                           logic [7:0] pa, logic [7:0] pb);
    via_port_res_t r;
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    func        <= f;
    reg_addr    <= a;
    write_data  <= d;
    port_a_pins <= pa;
    port_b_pins <= pb;
    do @(posedge clk); while (in_stall);
    r = predict_access(f, a, d, pa, pb);
    expected_results.push_back(r);
    n_items++;
    case (f)
      FUNC_TICK:  n_ticks++;
      FUNC_WRITE: n_writes++;
      FUNC_READ:  n_reads++;
      default:    n_ignored++;
    endcase
    n_upd_a += r.a_upd;
    n_upd_b += r.b_upd;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic write_reg(logic [3:0] a, logic [7:0] d);
    send_item(FUNC_WRITE, a, d, 8'($urandom), 8'($urandom));
  endtask

  task automatic read_reg(logic [3:0] a, logic [7:0] pa, logic [7:0] pb);
    send_item(FUNC_READ, a, 8'($urandom), pa, pb);
  endtask

  task automatic tick();
    send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and hold until every outstanding result has been checked
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    via_port_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none, got rd=%h a=%h b=%h",
                 $time, read_data, port_a_value, port_b_value);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        n_results++;
        check_field("read_data", want.rd, read_data);
        check_field("port_a_value", want.a_value, port_a_value);
        check_field("port_a_update", 8'(want.a_upd), 8'(port_a_update));
        check_field("port_b_value", want.b_value, port_b_value);
        check_field("port_b_update", 8'(want.b_upd), 8'(port_b_update));
      end
    end
  end

  // Receiver back-pressure: switch between free-running, light, heavy and periodic stalls
  int stall_mode = 0;
  int stall_span = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(20, 120);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ((stall_span % 8) < 3);
      endcase
    end
  end

  task automatic test_port_access();
    write_reg(ADDR_ORA, 8'hA5);            // no direction bits yet: no notify
    write_reg(ADDR_DDRA, 8'hFF);
    write_reg(ADDR_DDRA, 8'hFF);           // unchanged direction: no notify
    read_reg(ADDR_ORA, 8'h00, 8'h00);
    write_reg(ADDR_DDRB, 8'h0F);
    write_reg(ADDR_ORB, 8'hFF);
    read_reg(ADDR_ORB, 8'hFF, 8'hA0);
    write_reg(ADDR_ORANH, 8'h5A);
    write_reg(ADDR_DDRA, 8'h00);
    read_reg(ADDR_ORANH, 8'hFF, 8'h00);
    write_reg(ADDR_ACR, 8'h03);            // latched input on both ports
    read_reg(ADDR_ORA, 8'hFF, 8'hFF);
    read_reg(ADDR_ORB, 8'hFF, 8'hFF);
  endtask

  task automatic test_timers();
    write_reg(ADDR_ACR, 8'hC0);            // continuous, PB7 out
    write_reg(ADDR_T1CL, 8'h02);
    write_reg(ADDR_T1CH, 8'h00);
    tick();
    tick();                                // reload and toggle PB7
    read_reg(ADDR_T1CL, 8'h00, 8'h00);
    write_reg(ADDR_ACR, 8'h80);            // one-shot
    tick();
    tick();                                // hit zero: PB7 set
    write_reg(ADDR_T2CH, 8'h00);
    tick();                                // timer 2 wraps to all ones
    read_reg(ADDR_T2CH, 8'h00, 8'h00);
  endtask

  task automatic test_unmodelled_regs();
    write_reg(ADDR_SR, 8'hFF);
    read_reg(ADDR_IER, 8'hFF, 8'hFF);
    write_reg(ADDR_PCR, 8'hFF);
    read_reg(ADDR_PCR, 8'h00, 8'h00);
    send_item(FUNC_NONE, ADDR_ACR, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic random_access();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20)      tick();
    else if (roll < 55) write_reg(4'($urandom), 8'($urandom));
    else if (roll < 97) read_reg(4'($urandom), 8'($urandom), 8'($urandom));
    else send_item(FUNC_NONE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Load a short count into one timer, then tick it with random accesses mixed in
  task automatic timer_run();
    int n;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 1) == 0) write_reg(ADDR_ACR, 8'($urandom));
      write_reg(ADDR_T1LL, 8'($urandom_range(0, 7)));
      write_reg(ADDR_T1CH, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
    end else begin
      write_reg(ADDR_T2CL, 8'($urandom_range(0, 7)));
      write_reg(ADDR_T2CH, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
    end
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) random_access();
      else tick();
    end
  endtask

  task automatic test_random_traffic(int target);
    while (n_items < target) begin
      if ($urandom_range(0, 9) < 6) timer_run();
      else random_access();
    end
  endtask

  task automatic test_drain_pause();
    repeat (20) random_access();
    wait_drained();
    repeat (20) random_access();
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    func        = FUNC_TICK;
    reg_addr    = ADDR_ORB;
    write_data  = 8'h00;
    port_a_pins = 8'h00;
    port_b_pins = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_port_access();
    test_timers();
    test_unmodelled_regs();
    wait_drained();
    test_random_traffic(400);
    test_drain_pause();
    test_random_traffic(750);
    wait_drained();

    $display("Ran %0d items (%0d ticks, %0d writes, %0d reads, %0d ignored), %0d results checked",
             n_items, n_ticks, n_writes, n_reads, n_ignored, n_results);
    $display("Port A notified %0d times, port B %0d times; %0d mismatches",
             n_upd_a, n_upd_b, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
